FILE: rtl/core/rpcc_pkg.sv
`default_nettype none
package rpcc_pkg;

  localparam int MODEL_WORDS_DEF    = 16384;
  localparam int PIXEL_WORDS_DEF    = 65536;
  localparam int ROTATIONS_DEF      = 10;
  localparam int MAX_TREE_DEPTH_DEF = 8;
  localparam int ANGLE_COUNT        = 10;
  localparam logic [15:0] ROW_STRIDE_RESET = 16'd256;

  // cos and sin of k * 36 degrees, q1.14, truncated toward zero
  localparam logic signed [15:0] ROT_COS [ANGLE_COUNT] = '{
    16'sd16384, 16'sd13254, 16'sd5062, -16'sd5062, -16'sd13254,
    -16'sd16384, -16'sd13254, -16'sd5062, 16'sd5062, 16'sd13254};
  localparam logic signed [15:0] ROT_SIN [ANGLE_COUNT] = '{
    16'sd0, 16'sd9630, 16'sd15582, 16'sd15582, 16'sd9630,
    16'sd0, -16'sd9630, -16'sd15582, -16'sd15582, -16'sd9630};

  typedef enum logic [1:0] {
    CMD_LOAD_MODEL = 2'd0,
    CMD_LOAD_PIXEL = 2'd1,
    CMD_CLASSIFY   = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    VERDICT_EMPTY    = 2'd0,
    VERDICT_REJECTED = 2'd1,
    VERDICT_ACCEPTED = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    RD_ONE  = 2'd0,
    RD_POS  = 2'd1,
    RD_POS1 = 2'd2,
    RD_NODE = 2'd3
  } rd_sel_t;

  typedef enum logic [4:0] {
    S_IDLE, S_NST_RD, S_NST_W, S_STG_RD, S_STG_W, S_TREE, S_ODIM_W, S_DEP_W,
    S_NODE_RD, S_NODE_W, S_PIPE1, S_PIPE2, S_PIPE3, S_PIPE4, S_NODE_CMP,
    S_LEAF_W, S_THR_RD, S_THR_W, S_DONE
  } state_t;

  typedef struct packed {
    rd_sel_t  rd_sel;
    logic     wr_model;
    logic     wr_pixel;
    logic     load_item;
    logic     init_run;
    logic     ld_stages;
    logic     ld_trees;
    logic     ld_odim;
    logic     ld_depth;
    logic     node_step;
    logic     leaf_add;
    logic     ld_thr;
    logic     set_fin;
    verdict_t fin;
    logic     out_load;
  } ctl_t;

  typedef struct packed {
    logic rd_past;
    logic mdata_zero;
    logic tree_zero;
    logic walk_done;
    logic sum_le_thr;
    logic last_stage;
    logic out_full;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/rpcc_ctrl.sv
`default_nettype none
module rpcc_ctrl
  import rpcc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] command,
  input  wire sts_t       sts,
  output ctl_t            ctl
);

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && cmd_t'(command) == CMD_CLASSIFY) state_next = S_NST_RD;
      end
      S_NST_RD: state_next = S_NST_W;
      S_NST_W: state_next = sts.mdata_zero ? S_DONE : S_STG_RD;
      S_STG_RD: state_next = sts.rd_past ? S_DONE : S_STG_W;
      S_STG_W: state_next = S_TREE;
      S_TREE: begin
        if (sts.tree_zero) state_next = S_THR_RD;
        else if (sts.rd_past) state_next = S_DONE;
        else state_next = S_ODIM_W;
      end
      S_ODIM_W: state_next = sts.rd_past ? S_DONE : S_DEP_W;
      S_DEP_W: state_next = S_NODE_RD;
      S_NODE_RD: begin
        if (sts.rd_past) state_next = S_DONE;
        else if (sts.walk_done) state_next = S_LEAF_W;
        else state_next = S_NODE_W;
      end
      S_NODE_W: state_next = S_PIPE1;
      S_PIPE1: state_next = S_PIPE2;
      S_PIPE2: state_next = S_PIPE3;
      S_PIPE3: state_next = S_PIPE4;
      S_PIPE4: state_next = S_NODE_CMP;
      S_NODE_CMP: state_next = S_NODE_RD;
      S_LEAF_W: state_next = S_TREE;
      S_THR_RD: state_next = sts.rd_past ? S_DONE : S_THR_W;
      S_THR_W: begin
        if (sts.sum_le_thr || sts.last_stage) state_next = S_DONE;
        else state_next = S_STG_RD;
      end
      S_DONE: state_next = sts.out_full ? S_DONE : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.rd_sel = RD_POS;
    ctl.fin = VERDICT_REJECTED;
    unique case (state)
      S_IDLE: begin
        ctl.wr_model  = accept && cmd_t'(command) == CMD_LOAD_MODEL;
        ctl.wr_pixel  = accept && cmd_t'(command) == CMD_LOAD_PIXEL;
        ctl.load_item = accept && cmd_t'(command) == CMD_CLASSIFY;
      end
      S_NST_RD: ctl.rd_sel = RD_ONE;
      S_NST_W: begin
        if (sts.mdata_zero) begin
          ctl.set_fin = 1'b1;
          ctl.fin = VERDICT_EMPTY;
        end else begin
          ctl.ld_stages = 1'b1;
          ctl.init_run  = 1'b1;
        end
      end
      S_STG_RD: ctl.set_fin = sts.rd_past;
      S_STG_W: ctl.ld_trees = 1'b1;
      S_TREE: ctl.set_fin = !sts.tree_zero && sts.rd_past;
      S_ODIM_W: begin
        ctl.rd_sel  = RD_POS1;
        ctl.ld_odim = 1'b1;
        ctl.set_fin = sts.rd_past;
      end
      S_DEP_W: ctl.ld_depth = 1'b1;
      S_NODE_RD: begin
        ctl.rd_sel  = RD_NODE;
        ctl.set_fin = sts.rd_past;
      end
      S_NODE_W, S_PIPE1, S_PIPE2, S_PIPE3, S_PIPE4: ctl.rd_sel = RD_NODE;
      S_NODE_CMP: ctl.node_step = 1'b1;
      S_LEAF_W: ctl.leaf_add = 1'b1;
      S_THR_RD: ctl.set_fin = sts.rd_past;
      S_THR_W: begin
        ctl.ld_thr = 1'b1;
        if (sts.sum_le_thr) begin
          ctl.set_fin = 1'b1;
        end else if (sts.last_stage) begin
          ctl.set_fin = 1'b1;
          ctl.fin = VERDICT_ACCEPTED;
        end
      end
      S_DONE: ctl.out_load = !sts.out_full;
      default: ctl = '0;
    endcase
  end

  a_cmp_after_pipe: assert property (@(posedge clk) disable iff (rst)
    state == S_NODE_CMP |-> $past(state, 5) == S_NODE_W)
    else $error("node compare without full address pipe");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> !sts.out_full)
    else $error("result loaded over a waiting word");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && state_next == S_IDLE |-> ctl.out_load)
    else $error("classify finished without a result");

endmodule
`default_nettype wire

FILE: rtl/core/rpcc_datapath.sv
`default_nettype none
module rpcc_datapath
  import rpcc_pkg::*;
#(
  parameter int MODEL_WORDS    = MODEL_WORDS_DEF,
  parameter int PIXEL_WORDS    = PIXEL_WORDS_DEF,
  parameter int ROTATIONS      = ROTATIONS_DEF,
  parameter int MAX_TREE_DEPTH = MAX_TREE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [15:0] cfg_data,
  input  wire logic        [15:0] address,
  input  wire logic        [31:0] data,
  input  wire logic        [9:0]  center_row,
  input  wire logic        [9:0]  center_col,
  input  wire logic        [9:0]  region_size,
  input  wire logic        [3:0]  rotation,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic             [1:0]  verdict,
  output logic signed      [31:0] score,
  input  wire ctl_t               ctl,
  output sts_t                    sts
);

  // memory depths are powers of two
  localparam int AW  = $clog2(MODEL_WORDS);
  localparam int PXW = $clog2(PIXEL_WORDS);
  localparam int DW  = $clog2(MAX_TREE_DEPTH + 1);
  localparam int IW  = MAX_TREE_DEPTH + 1;
  localparam int PW  = AW + MAX_TREE_DEPTH + 2;

  logic [31:0]   mmem [MODEL_WORDS];
  logic [7:0]    pmem [PIXEL_WORDS];

  logic [15:0]   row_stride;
  logic [31:0]   mdata;
  logic [9:0]    reg_row, reg_col, reg_size;
  logic [3:0]    ang;
  logic [3:0]    angle_lut [16];
  logic [AW:0]   pos;
  logic [31:0]   stage_cnt, tree_cnt, odim;
  logic [DW-1:0] depth, walk_k;
  logic [IW-1:0] idx;
  logic signed [31:0] sum, thr;
  verdict_t      fin, out_verdict;

  logic [PW-1:0] rd_addr, pos_sum, inc;
  logic [DW-1:0] depth_sat;
  logic          odim_hi;

  logic signed [24:0] s1_tr [2];
  logic signed [24:0] s1_tc [2];
  logic signed [22:0] s2_vr [2];
  logic signed [22:0] s2_vc [2];
  logic signed [14:0] s3_row [2];
  logic signed [14:0] s3_col [2];
  logic [PXW-1:0]     s4_addr [2];
  logic [7:0]         pix [2];
  logic signed [15:0] rc, rs;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sd2147483647) return 32'sh7fffffff;
    if (v < -33'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  genvar gi;
  for (gi = 0; gi < 16; gi++) begin : g_ang
    assign angle_lut[gi] = 4'((gi % ROTATIONS) % ANGLE_COUNT);
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_stride <= ROW_STRIDE_RESET;
    end else if (cfg_valid) begin
      row_stride <= cfg_data;
    end
  end

  always_comb begin
    unique case (ctl.rd_sel)
      RD_ONE:  rd_addr = PW'(1);
      RD_POS:  rd_addr = PW'(pos);
      RD_POS1: rd_addr = PW'(pos) + PW'(1);
      RD_NODE: rd_addr = PW'(pos) + PW'(idx) + PW'(2);
      default: rd_addr = PW'(pos);
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_model) mmem[AW'(address)] <= data;
    mdata <= mmem[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_pixel) pmem[PXW'(address)] <= data[7:0];
    pix[0] <= pmem[s4_addr[0]];
    pix[1] <= pmem[s4_addr[1]];
  end

  // offset rotation, scaling and pixel address, four stages per pixel
  assign rc = ROT_COS[ang];
  assign rs = ROT_SIN[ang];

  for (gi = 0; gi < 2; gi++) begin : g_px
    logic signed [7:0]  dr, dc;
    logic signed [10:0] rr, rcl;
    logic signed [10:0] szs;
    logic signed [32:0] a;
    assign dr  = mdata[16*gi +: 8];
    assign dc  = mdata[16*gi + 8 +: 8];
    assign szs = {1'b0, reg_size};
    assign rr  = 11'((s1_tr[gi] + (s1_tr[gi][24] ? 25'sd16383 : 25'sd0)) >>> 14);
    assign rcl = 11'((s1_tc[gi] + (s1_tc[gi][24] ? 25'sd16383 : 25'sd0)) >>> 14);
    assign a   = 33'(s3_row[gi]) * $signed({17'd0, row_stride}) + 33'(s3_col[gi]);

    always_ff @(posedge clk) begin
      s1_tr[gi]  <= 25'(dr * rc) + 25'(dc * rs);
      s1_tc[gi]  <= 25'(dc * rc) - 25'(dr * rs);
      s2_vr[gi]  <= $signed({5'd0, reg_row, 8'd0}) + 23'(rr * szs);
      s2_vc[gi]  <= $signed({5'd0, reg_col, 8'd0}) + 23'(rcl * szs);
      s3_row[gi] <= 15'((s2_vr[gi] + (s2_vr[gi][22] ? 23'sd255 : 23'sd0)) >>> 8);
      s3_col[gi] <= 15'((s2_vc[gi] + (s2_vc[gi][22] ? 23'sd255 : 23'sd0)) >>> 8);
      s4_addr[gi] <= a[PXW-1:0];
    end
  end

  // pointer advance over one tree, clamped at the end of the model
  assign depth_sat = (mdata > 32'(MAX_TREE_DEPTH)) ? DW'(MAX_TREE_DEPTH) : mdata[DW-1:0];
  assign odim_hi   = |odim[31:AW];
  assign inc       = (PW'(odim[AW-1:0]) << depth) + (PW'(1) << depth) + PW'(1);
  assign pos_sum   = PW'(pos) + inc;

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      reg_row  <= center_row;
      reg_col  <= center_col;
      reg_size <= region_size;
      ang      <= angle_lut[rotation];
    end
    if (ctl.init_run) begin
      pos <= (AW+1)'(2);
      sum <= '0;
      thr <= '0;
    end
    if (ctl.ld_stages) stage_cnt <= mdata;
    if (ctl.ld_trees) begin
      tree_cnt <= mdata;
      pos <= pos + 1'b1;
    end
    if (ctl.ld_odim) odim <= mdata;
    if (ctl.ld_depth) begin
      depth  <= depth_sat;
      walk_k <= '0;
      idx    <= '0;
    end
    if (ctl.node_step) begin
      idx    <= {idx[IW-2:0], 1'b0} + ((pix[0] <= pix[1]) ? IW'(1) : IW'(2));
      walk_k <= walk_k + 1'b1;
    end
    if (ctl.leaf_add) begin
      sum      <= sat33(33'(sum) + 33'($signed(mdata)));
      tree_cnt <= tree_cnt - 1'b1;
      if (odim_hi || pos_sum >= PW'(MODEL_WORDS)) pos <= (AW+1)'(MODEL_WORDS);
      else pos <= pos_sum[AW:0];
    end
    if (ctl.ld_thr) begin
      thr       <= $signed(mdata);
      pos       <= pos + 1'b1;
      stage_cnt <= stage_cnt - 1'b1;
    end
    if (ctl.set_fin) fin <= ctl.fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_verdict <= fin;
      unique case (fin)
        VERDICT_EMPTY:    score <= '0;
        VERDICT_ACCEPTED: score <= sat33(33'(sum) - 33'(thr));
        default:          score <= sum;
      endcase
    end
  end

  assign verdict = 2'(out_verdict);

  assign sts.rd_past    = rd_addr >= PW'(MODEL_WORDS);
  assign sts.mdata_zero = (mdata == '0);
  assign sts.tree_zero  = (tree_cnt == '0);
  assign sts.walk_done  = (walk_k == depth);
  assign sts.sum_le_thr = sum <= $signed(mdata);
  assign sts.last_stage = (stage_cnt == 32'd1);
  assign sts.out_full   = out_valid && !out_ready;

endmodule
`default_nettype wire

FILE: rtl/core/rotated_pixel_cascade_classifier_core.sv
`default_nettype none
// channel  handshake              payload
// cfg      cfg_valid/cfg_ready    cfg_data (row_stride)
// in       in_valid/in_ready      command, address, data, center_row/col, region_size, rotation
// out      out_valid/out_ready    verdict, score
//
// a load word is written into its memory as it is taken; a classify word reads the stage count,
// then per stage its tree count, per tree a header, node walk and leaf, and the stage threshold
// and hands over the result; each node visit is paced by the single model memory read port
// and the four-stage pixel address pipe; both pixels of a node are read together on two ports
// reset clears the controller and sets row_stride to 256; memories are not cleared
// a result waits in an output register; the next word is taken once it is loaded
module rotated_pixel_cascade_classifier_core
  import rpcc_pkg::*;
#(
  parameter int MODEL_WORDS    = MODEL_WORDS_DEF,
  parameter int PIXEL_WORDS    = PIXEL_WORDS_DEF,
  parameter int ROTATIONS      = ROTATIONS_DEF,
  parameter int MAX_TREE_DEPTH = MAX_TREE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [15:0] cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic        [1:0]  command,
  input  wire logic        [15:0] address,
  input  wire logic        [31:0] data,
  input  wire logic        [9:0]  center_row,
  input  wire logic        [9:0]  center_col,
  input  wire logic        [9:0]  region_size,
  input  wire logic        [3:0]  rotation,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic             [1:0]  verdict,
  output logic signed      [31:0] score
);

  ctl_t ctl;
  sts_t sts;

  rpcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .sts      (sts),
    .ctl      (ctl)
  );

  rpcc_datapath #(
    .MODEL_WORDS    (MODEL_WORDS),
    .PIXEL_WORDS    (PIXEL_WORDS),
    .ROTATIONS      (ROTATIONS),
    .MAX_TREE_DEPTH (MAX_TREE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .address     (address),
    .data        (data),
    .center_row  (center_row),
    .center_col  (center_col),
    .region_size (region_size),
    .rotation    (rotation),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .verdict     (verdict),
    .score       (score),
    .ctl         (ctl),
    .sts         (sts)
  );

endmodule
`default_nettype wire
